// ===== sv/edn_pkg.sv =====
// ----------------------------------------------------------------------------
// edn_pkg
// Shared types and fixed field widths for the Euclidean distance core.
// ----------------------------------------------------------------------------
package edn_pkg;

    // Fixed port field widths
    localparam int COORD_W     = 16;
    localparam int DIST_W      = 25;
    localparam int TOL_W       = 16;
    localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;

    // Front-to-back queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== sv/edn_front.sv =====
// ----------------------------------------------------------------------------
// edn_front
// Accepts point pairs, forms |dx|, |dy|, their squares and the scaled radicand.
// ----------------------------------------------------------------------------
module edn_front import edn_pkg::*; #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8,
    parameter int RW         = 49
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [COORD_W-1:0]  s_first_x,
    input  logic [COORD_W-1:0]  s_first_y,
    input  logic [COORD_W-1:0]  s_second_x,
    input  logic [COORD_W-1:0]  s_second_y,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                out_zero,
    output logic [RW-1:0]       out_rad
);

    localparam int CIN  = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
    localparam int SUMW = 2 * CIN + 1;
    localparam int FW   = SUMW + 2 * FRAC_BITS;

    logic signed [CIN:0] ax, ay, bx, by, dx, dy;
    logic [CIN-1:0]      mx, my;
    logic [CIN-1:0]      mx_reg, my_reg;
    logic                a_valid_reg, b_valid_reg;
    logic [2*CIN-1:0]    sqx_reg, sqy_reg;
    logic [2*CIN-1:0]    sqx_next, sqy_next;
    logic [SUMW-1:0]     sum;
    logic [FW-1:0]       rad_full;
    logic                a_adv, b_adv;

    // sign-extend from the coordinate width
    assign ax = (CIN+1)'(signed'(s_first_x[CIN-1:0]));
    assign ay = (CIN+1)'(signed'(s_first_y[CIN-1:0]));
    assign bx = (CIN+1)'(signed'(s_second_x[CIN-1:0]));
    assign by = (CIN+1)'(signed'(s_second_y[CIN-1:0]));
    assign dx = bx - ax;
    assign dy = by - ay;
    assign mx = dx[CIN] ? CIN'(-dx) : CIN'(dx);
    assign my = dy[CIN] ? CIN'(-dy) : CIN'(dy);

    assign sqx_next = (2*CIN)'(mx_reg) * (2*CIN)'(mx_reg);
    assign sqy_next = (2*CIN)'(my_reg) * (2*CIN)'(my_reg);

    assign sum      = SUMW'(sqx_reg) + SUMW'(sqy_reg);
    assign rad_full = FW'(sum) << (2 * FRAC_BITS);
    assign out_rad  = rad_full[RW-1:0];
    assign out_zero = (out_rad == '0);

    assign b_adv     = !b_valid_reg || out_ready;
    assign a_adv     = !a_valid_reg || b_adv;
    assign s_ready   = a_adv;
    assign out_valid = b_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (a_adv) begin
                a_valid_reg <= s_valid;
                mx_reg      <= mx;
                my_reg      <= my;
            end
            if (b_adv) begin
                b_valid_reg <= a_valid_reg;
                sqx_reg     <= sqx_next;
                sqy_reg     <= sqy_next;
            end
        end
    end

endmodule

// ===== sv/edn_queue.sv =====
// ----------------------------------------------------------------------------
// edn_queue
// Short FIFO that decouples the front stages from the root sequencer.
// ----------------------------------------------------------------------------
module edn_queue import edn_pkg::*; #(
    parameter int W = 50
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [W-1:0]  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [W-1:0]  out_data
);

    logic [W-1:0]      mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              push, pop;

    assign in_ready  = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== sv/edn_div.sv =====
// ----------------------------------------------------------------------------
// edn_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module edn_div import edn_pkg::*; #(
    parameter int W = 49
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [W-1:0]  dividend,
    input  logic [W-1:0]  divisor,
    output logic [W-1:0]  quotient,
    output div_stat_t     stat
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  rem_reg, quo_reg, dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, done_reg;
    logic [W:0]    trial, trial_sub;
    logic          fits;
    logic [W-1:0]  rem_next;

    // shift next dividend bit into the partial remainder
    assign trial     = {rem_reg, quo_reg[W-1]};
    assign trial_sub = trial - {1'b0, dvs_reg};
    assign fits      = (trial >= {1'b0, dvs_reg});
    assign rem_next  = fits ? trial_sub[W-1:0] : trial[W-1:0];

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
                cnt_reg  <= CW'(W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                quo_reg <= {quo_reg[W-2:0], fits};
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== sv/edn_back.sv =====
// ----------------------------------------------------------------------------
// edn_back
// Newton square-root sequencer with tolerance test and result register.
// ----------------------------------------------------------------------------
module edn_back import edn_pkg::*; #(
    parameter int RW       = 49,
    parameter int MAX_ITER = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    output logic              q_ready,
    input  logic              q_zero,
    input  logic [RW-1:0]     q_rad,
    input  logic [TOL_W-1:0]  tolerance,
    output logic              div_start,
    output logic [RW-1:0]     div_dividend,
    output logic [RW-1:0]     div_divisor,
    input  logic [RW-1:0]     div_quot,
    input  div_stat_t         div_stat,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [DIST_W-1:0] m_distance,
    output logic              m_iteration_capped
);

    localparam int KW = $clog2(MAX_ITER + 1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_DIFF, ST_DEC, ST_DIV, ST_UPD, ST_OUT
    } state_t;

    state_t            state_reg;
    logic [RW-1:0]     rad_reg, est_reg;
    logic [63:0]       sq_reg, diff_reg;
    logic              hi_reg;
    logic [KW-1:0]     iter_reg;
    logic              capped_reg;
    logic              m_valid_reg, m_capped_reg;
    logic [DIST_W-1:0] m_distance_reg;

    logic [63:0]       est64, rad64;
    logic [RW:0]       est_sum;
    logic [RW-1:0]     est_half, est_next, est_init, rad_half;
    logic              pass, at_cap;

    assign est64    = 64'(est_reg);
    assign rad64    = 64'(rad_reg);
    assign est_sum  = {1'b0, est_reg} + {1'b0, div_quot};
    assign est_half = est_sum[RW:1];
    assign est_next = (est_half == '0) ? RW'(1) : est_half;
    assign rad_half = q_rad >> 1;
    assign est_init = (rad_half == '0) ? RW'(1) : rad_half;

    // estimates of 2^32 and up never pass
    assign pass   = !hi_reg && (diff_reg <= 64'(tolerance));
    assign at_cap = (iter_reg == KW'(MAX_ITER));

    assign q_ready      = (state_reg == ST_IDLE);
    assign div_start    = (state_reg == ST_DEC) && !pass && !at_cap;
    assign div_dividend = rad_reg;
    assign div_divisor  = est_reg;

    assign m_valid            = m_valid_reg;
    assign m_distance         = m_distance_reg;
    assign m_iteration_capped = m_capped_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            iter_reg    <= '0;
            capped_reg  <= 1'b0;
        end else begin
            // in ST_OUT the result load below owns m_valid_reg
            if (m_valid_reg && m_ready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        rad_reg    <= q_rad;
                        iter_reg   <= '0;
                        capped_reg <= 1'b0;
                        if (q_zero) begin
                            est_reg   <= '0;
                            state_reg <= ST_OUT;
                        end else begin
                            est_reg   <= est_init;
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_MUL: begin
                    sq_reg    <= 64'(est64[31:0]) * 64'(est64[31:0]);
                    hi_reg    <= |est64[63:32];
                    state_reg <= ST_DIFF;
                end
                ST_DIFF: begin
                    diff_reg  <= (sq_reg >= rad64) ? (sq_reg - rad64) : (rad64 - sq_reg);
                    state_reg <= ST_DEC;
                end
                ST_DEC: begin
                    if (pass) begin
                        capped_reg <= 1'b0;
                        state_reg  <= ST_OUT;
                    end else if (at_cap) begin
                        capped_reg <= 1'b1;
                        state_reg  <= ST_OUT;
                    end else begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_stat.done) begin
                        state_reg <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    if (est_next >= est_reg) begin
                        capped_reg <= 1'b0;
                        state_reg  <= ST_OUT;
                    end else begin
                        est_reg   <= est_next;
                        iter_reg  <= iter_reg + 1'b1;
                        state_reg <= ST_MUL;
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg    <= 1'b1;
                        m_distance_reg <= est64[DIST_W-1:0];
                        m_capped_reg   <= capped_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== sv/euclidean_distance_newton_sqrt_core.sv =====
// ----------------------------------------------------------------------------
// euclidean_distance_newton_sqrt_core
// Distance between two integer points, square root by Newton iteration.
// ----------------------------------------------------------------------------
// Each transaction on the s_ channel carries two points; one transaction on
// the m_ channel returns their distance in unsigned fixed point with
// FRAC_BITS fraction bits (masked to 25 bits) plus a flag that is set when
// MAX_ITER Newton steps ran out before the tolerance test passed. A two-stage
// front forms |dx|, |dy|, the squares and the radicand and drops it into a
// two-entry queue, so new points are taken while a root is being worked
// out. The back end iterates one item at a time: each Newton step squares
// the estimate, tests its distance from the radicand against the tolerance
// and, if that fails, divides in the bit-serial divider (RW = radicand width,
// 49 bits at the defaults) and averages. From a start of r/2 the estimate
// roughly halves per step until it nears the root, so large distances take
// some 20 to 30 steps and short ones far fewer; equal points skip the steps.
// The tolerance register (reset 1) is written through the cfg_ port and
// should only be changed while no transaction is in flight.
// ----------------------------------------------------------------------------
module euclidean_distance_newton_sqrt_core import edn_pkg::*; #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8,
    parameter int MAX_ITER   = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration write
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [TOL_W-1:0]   cfg_tolerance,
    // point pairs in
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [COORD_W-1:0] s_first_x,
    input  logic [COORD_W-1:0] s_first_y,
    input  logic [COORD_W-1:0] s_second_x,
    input  logic [COORD_W-1:0] s_second_y,
    // distances out
    output logic               m_valid,
    input  logic               m_ready,
    output logic [DIST_W-1:0]  m_distance,
    output logic               m_iteration_capped
);

    // radicand width: (dx^2 + dy^2) scaled by 2^(2*FRAC_BITS), wraps at 64
    localparam int CIN   = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
    localparam int FULLW = 2 * CIN + 1 + 2 * FRAC_BITS;
    localparam int RW    = (FULLW > 64) ? 64 : FULLW;

    logic [TOL_W-1:0] tolerance_reg;

    logic             f_valid, f_ready, f_zero;
    logic [RW-1:0]    f_rad;
    logic             q_valid, q_ready, q_zero;
    logic [RW-1:0]    q_rad;

    logic             div_start;
    logic [RW-1:0]    div_dividend, div_divisor, div_quot;
    div_stat_t        div_stat;

    // tolerance register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tolerance_reg <= TOL_RESET;
        end else if (cfg_valid) begin
            tolerance_reg <= cfg_tolerance;
        end
    end

    edn_front #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .RW         (RW)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_first_x  (s_first_x),
        .s_first_y  (s_first_y),
        .s_second_x (s_second_x),
        .s_second_y (s_second_y),
        .out_valid  (f_valid),
        .out_ready  (f_ready),
        .out_zero   (f_zero),
        .out_rad    (f_rad)
    );

    // zero flag travels in the top bit of each queue entry
    edn_queue #(
        .W (RW + 1)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   ({f_zero, f_rad}),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  ({q_zero, q_rad})
    );

    edn_div #(
        .W (RW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quot),
        .stat     (div_stat)
    );

    edn_back #(
        .RW       (RW),
        .MAX_ITER (MAX_ITER)
    ) u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .q_valid            (q_valid),
        .q_ready            (q_ready),
        .q_zero             (q_zero),
        .q_rad              (q_rad),
        .tolerance          (tolerance_reg),
        .div_start          (div_start),
        .div_dividend       (div_dividend),
        .div_divisor        (div_divisor),
        .div_quot           (div_quot),
        .div_stat           (div_stat),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_distance         (m_distance),
        .m_iteration_capped (m_iteration_capped)
    );

    // reset leaves no stale result on the output
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid set right after reset");

    // the sequencer never restarts a division in progress
    a_div_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    // a finished division leaves the divider free
    a_div_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> !div_stat.busy)
        else $error("divider done while still busy");

    // a radicand pushed into the queue is visible to the back end next cycle
    a_queue_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (f_valid && f_ready) |=> q_valid)
        else $error("queue push lost");

endmodule
